// ===== rtl/gzmh_pkg.sv =====
// Package: shared types and constants for the gzip member header parser.
`default_nettype none

package gzmh_pkg;

  localparam logic [7:0] MAGIC_FIRST    = 8'h1f;
  localparam logic [7:0] MAGIC_SECOND   = 8'h8b;
  localparam logic [7:0] METHOD_DEFLATE = 8'd8;
  localparam logic [7:0] FLAGS_RESERVED = 8'hE0;
  localparam logic [15:0] FIXED_SKIP_LEN = 16'd6;

  // Flag bit positions inside the five captured flag bits
  localparam int unsigned FLB_HCRC    = 1;
  localparam int unsigned FLB_EXTRA   = 2;
  localparam int unsigned FLB_NAME    = 3;
  localparam int unsigned FLB_COMMENT = 4;

  typedef enum logic [2:0] {
    K_HEADER    = 3'd0,
    K_LAST      = 3'd1,
    K_PAYLOAD   = 3'd2,
    K_BADMAGIC  = 3'd3,
    K_BADMETHOD = 3'd4,
    K_BADFLAGS  = 3'd5
  } kind_t;

  typedef enum logic [13:0] {
    PH_MAGIC1  = 14'b00000000000001,
    PH_MAGIC2  = 14'b00000000000010,
    PH_METHOD  = 14'b00000000000100,
    PH_FLAGS   = 14'b00000000001000,
    PH_FIXED   = 14'b00000000010000,
    PH_XLEN_LO = 14'b00000000100000,
    PH_XLEN_HI = 14'b00000001000000,
    PH_XSKIP   = 14'b00000010000000,
    PH_NAME    = 14'b00000100000000,
    PH_COMMENT = 14'b00001000000000,
    PH_HCRC_LO = 14'b00010000000000,
    PH_HCRC_HI = 14'b00100000000000,
    PH_PAYLOAD = 14'b01000000000000,
    PH_ERROR   = 14'b10000000000000
  } phase_t;

  // Header section just finished by the current byte
  typedef enum logic [2:0] {
    SEC_FIXED   = 3'd0,
    SEC_EXTRA   = 3'd1,
    SEC_NAME    = 3'd2,
    SEC_COMMENT = 3'd3,
    SEC_HCRC    = 3'd4
  } section_t;

endpackage : gzmh_pkg

`default_nettype wire

// ===== rtl/gzmh_if.sv =====
// Interfaces: valid/ready byte input channel and result channel.
`default_nettype none

interface gzmh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_member;

  modport source (output valid, output data_byte, output start_of_member, input ready);
  modport sink   (input valid, input data_byte, input start_of_member, output ready);
endinterface : gzmh_in_if

interface gzmh_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  byte_out;
  logic [4:0]  header_flags;
  logic [15:0] stored_header_crc;

  modport source (output valid, output kind, output byte_out, output header_flags,
                  output stored_header_crc, input ready);
  modport sink   (input valid, input kind, input byte_out, input header_flags,
                  input stored_header_crc, output ready);
endinterface : gzmh_out_if

`default_nettype wire

// ===== rtl/gzip_member_header_parser.sv =====
// Top level: gzip member header parser, one byte per cycle while the result register is not stalled.
// Each transferred byte's result is loaded into the result register at the edge that takes the byte.
// Throughput: one byte per cycle; the single result register sets the pace, and the
//   input is taken whenever that register is empty or is being emptied in the same cycle.
// Reset: synchronous, active-low rst_n; parser returns to "expect first magic byte"
//   with flags, skip count, held byte and captured header CRC cleared, output empty.
`default_nettype none

module gzip_member_header_parser
  import gzmh_pkg::*;
(
  input  wire          clk,
  input  wire          rst_n,
  gzmh_in_if.sink      in_if,
  gzmh_out_if.source   out_if
);

  // Parser state
  phase_t      phase_r,    phase_nxt;
  logic [4:0]  flags_r,    flags_nxt;
  logic [15:0] skip_r,     skip_nxt;
  logic [7:0]  held_r,     held_nxt;
  logic [15:0] hcrc_r,     hcrc_nxt;

  // Result register
  logic        out_valid_r;
  kind_t       kind_r,     kind_nxt;
  logic [7:0]  byte_r;

  logic        in_fire;

  // Take a new byte when the result register is empty or drains this cycle
  assign in_if.ready = !out_valid_r || out_if.ready;
  assign in_fire     = in_if.valid && in_if.ready;

  // Pick the next optional section after the one just finished
  function automatic phase_t next_section(input section_t done, input logic [4:0] fl);
    phase_t ph;
    ph = PH_PAYLOAD;
    priority if (done < SEC_EXTRA && fl[FLB_EXTRA])       ph = PH_XLEN_LO;
    else if (done < SEC_NAME && fl[FLB_NAME])             ph = PH_NAME;
    else if (done < SEC_COMMENT && fl[FLB_COMMENT])       ph = PH_COMMENT;
    else if (done < SEC_HCRC && fl[FLB_HCRC])             ph = PH_HCRC_LO;
    else                                                  ph = PH_PAYLOAD;
    return ph;
  endfunction

  always_comb begin
    phase_t      ph;
    logic [4:0]  fl;
    logic [15:0] sk;
    logic [7:0]  hb;
    logic [15:0] hc;
    logic [7:0]  b;
    logic        done_vld;
    section_t    done_sec;

    b        = in_if.data_byte;
    ph       = phase_r;
    fl       = flags_r;
    sk       = skip_r;
    hb       = held_r;
    hc       = hcrc_r;
    done_vld = 1'b0;
    done_sec = SEC_FIXED;
    kind_nxt = K_HEADER;

    // A start mark restarts the header walk with everything cleared
    if (in_if.start_of_member) begin
      ph = PH_MAGIC1;
      fl = '0;
      sk = '0;
      hb = '0;
      hc = '0;
    end

    phase_nxt = ph;
    flags_nxt = fl;
    skip_nxt  = sk;
    held_nxt  = hb;
    hcrc_nxt  = hc;

    unique case (ph)
      PH_MAGIC1: begin
        held_nxt  = b;
        phase_nxt = PH_MAGIC2;
      end
      PH_MAGIC2: begin
        if (hb != MAGIC_FIRST || b != MAGIC_SECOND) begin
          kind_nxt  = K_BADMAGIC;
          phase_nxt = PH_ERROR;
        end else begin
          phase_nxt = PH_METHOD;
        end
      end
      PH_METHOD: begin
        if (b != METHOD_DEFLATE) begin
          kind_nxt  = K_BADMETHOD;
          phase_nxt = PH_ERROR;
        end else begin
          phase_nxt = PH_FLAGS;
        end
      end
      PH_FLAGS: begin
        if ((b & FLAGS_RESERVED) != 8'd0) begin
          kind_nxt  = K_BADFLAGS;
          phase_nxt = PH_ERROR;
        end else begin
          flags_nxt = b[4:0];
          skip_nxt  = FIXED_SKIP_LEN;
          phase_nxt = PH_FIXED;
        end
      end
      PH_FIXED: begin
        skip_nxt = sk - 16'd1;
        if (skip_nxt == 16'd0) begin
          done_vld = 1'b1;
          done_sec = SEC_FIXED;
        end
      end
      PH_XLEN_LO: begin
        held_nxt  = b;
        phase_nxt = PH_XLEN_HI;
      end
      PH_XLEN_HI: begin
        skip_nxt = {b, hb};
        if (skip_nxt == 16'd0) begin
          done_vld = 1'b1;
          done_sec = SEC_EXTRA;
        end else begin
          phase_nxt = PH_XSKIP;
        end
      end
      PH_XSKIP: begin
        skip_nxt = sk - 16'd1;
        if (skip_nxt == 16'd0) begin
          done_vld = 1'b1;
          done_sec = SEC_EXTRA;
        end
      end
      PH_NAME: begin
        if (b == 8'd0) begin
          done_vld = 1'b1;
          done_sec = SEC_NAME;
        end
      end
      PH_COMMENT: begin
        if (b == 8'd0) begin
          done_vld = 1'b1;
          done_sec = SEC_COMMENT;
        end
      end
      PH_HCRC_LO: begin
        held_nxt  = b;
        phase_nxt = PH_HCRC_HI;
      end
      PH_HCRC_HI: begin
        hcrc_nxt = {b, hb};
        done_vld = 1'b1;
        done_sec = SEC_HCRC;
      end
      PH_PAYLOAD: begin
        kind_nxt = K_PAYLOAD;
      end
      default: begin
        // Error is sticky until the next start mark
        kind_nxt  = K_BADFLAGS;
        phase_nxt = PH_ERROR;
      end
    endcase

    // Advance to the next present section; mark the header's final byte
    if (done_vld) begin
      phase_nxt = next_section(done_sec, flags_nxt);
      if (phase_nxt == PH_PAYLOAD) kind_nxt = K_LAST;
    end
  end

  // Parser state advances on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_MAGIC1;
      flags_r <= '0;
      skip_r  <= '0;
      held_r  <= '0;
      hcrc_r  <= '0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      flags_r <= flags_nxt;
      skip_r  <= skip_nxt;
      held_r  <= held_nxt;
      hcrc_r  <= hcrc_nxt;
    end
  end

  // Result valid: set on input transfer, drop once the output transfer completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload: hold while stalled
  logic [4:0]  out_flags_r;
  logic [15:0] out_hcrc_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r      <= kind_nxt;
      byte_r      <= in_if.data_byte;
      out_flags_r <= flags_nxt;
      out_hcrc_r  <= hcrc_nxt;
    end
  end

  assign out_if.valid             = out_valid_r;
  assign out_if.kind              = kind_r;
  assign out_if.byte_out          = byte_r;
  assign out_if.header_flags      = out_flags_r;
  assign out_if.stored_header_crc = out_hcrc_r;

  // A stalled result must block new input
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_if.ready) |-> !in_if.ready)
    else $error("input taken while result stalled");

  // A magic or method error leaves the parser in the sticky error phase
  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (kind_nxt == K_BADMAGIC || kind_nxt == K_BADMETHOD))
      |=> (phase_r == PH_ERROR))
    else $error("error kind without entering error phase");

  // The last header byte hands over to payload
  a_last_to_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && kind_nxt == K_LAST) |=> (phase_r == PH_PAYLOAD))
    else $error("last header byte not followed by payload phase");

  // A start mark consumes the first magic byte with captures cleared
  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_if.start_of_member)
      |=> (phase_r == PH_MAGIC2 && flags_r == 5'd0 && hcrc_r == 16'd0))
    else $error("restart did not clear parser state");

endmodule : gzip_member_header_parser

`default_nettype wire

// ===== test/tb_gzip_member_header_parser.sv =====
// Testbench for the gzip member header parser: random and directed byte streams, scoreboarded.
`default_nettype none

module tb_gzip_member_header_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import gzmh_pkg::*;

  // Generous cycle ceiling: roughly 2000 bytes at worst-case gaps and stalls, plus the long hold
  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_BYTES = 1600;
  // Cycles the receiver is held off once, long enough to back the block up into its input
  localparam int LONG_HOLD = 200;
  // Quiet cycles after the last result, to catch anything spurious
  localparam int TAIL_CYCLES = 8;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [4:0]  flags;
    logic [15:0] crc;
  } parse_result_t;

  // Tracks the header walk of the byte stream and holds the results still due from the block
  class gzip_header_tracker;
    phase_t          ph;
    logic [4:0]      flag_bits;
    logic [15:0]     skip_left;
    logic [7:0]      held;
    logic [15:0]     hcrc;
    parse_result_t   results_due[$];
    int              mismatches;
    int              kind_tally[6];

    function new();
      ph = PH_MAGIC1;
      flag_bits = '0;
      skip_left = '0;
      held = '0;
      hcrc = '0;
      mismatches = 0;
      foreach (kind_tally[i]) kind_tally[i] = 0;
    endfunction

    // Advance the parse by one transferred byte and queue the result it must produce
    function void note_byte(logic [7:0] b, logic mark);
      kind_t         k;
      logic          fin;
      section_t      sec;
      parse_result_t r;
      k = K_HEADER;
      fin = 1'b0;
      sec = SEC_FIXED;
      if (mark) begin
        ph = PH_MAGIC1;
        flag_bits = '0;
        skip_left = '0;
        held = '0;
        hcrc = '0;
      end
      case (ph)
        PH_MAGIC1: begin
          held = b;
          ph = PH_MAGIC2;
        end
        PH_MAGIC2: begin
          if (held != MAGIC_FIRST || b != MAGIC_SECOND) begin
            k = K_BADMAGIC;
            ph = PH_ERROR;
          end else begin
            ph = PH_METHOD;
          end
        end
        PH_METHOD: begin
          if (b != METHOD_DEFLATE) begin
            k = K_BADMETHOD;
            ph = PH_ERROR;
          end else begin
            ph = PH_FLAGS;
          end
        end
        PH_FLAGS: begin
          if ((b & FLAGS_RESERVED) != 8'h00) begin
            k = K_BADFLAGS;
            ph = PH_ERROR;
          end else begin
            flag_bits = b[4:0];
            skip_left = FIXED_SKIP_LEN;
            ph = PH_FIXED;
          end
        end
        PH_FIXED: begin
          skip_left = skip_left - 16'd1;
          if (skip_left == 16'd0) begin
            fin = 1'b1;
            sec = SEC_FIXED;
          end
        end
        PH_XLEN_LO: begin
          held = b;
          ph = PH_XLEN_HI;
        end
        PH_XLEN_HI: begin
          skip_left = {b, held};
          if (skip_left == 16'd0) begin
            fin = 1'b1;
            sec = SEC_EXTRA;
          end else begin
            ph = PH_XSKIP;
          end
        end
        PH_XSKIP: begin
          skip_left = skip_left - 16'd1;
          if (skip_left == 16'd0) begin
            fin = 1'b1;
            sec = SEC_EXTRA;
          end
        end
        PH_NAME: begin
          if (b == 8'h00) begin
            fin = 1'b1;
            sec = SEC_NAME;
          end
        end
        PH_COMMENT: begin
          if (b == 8'h00) begin
            fin = 1'b1;
            sec = SEC_COMMENT;
          end
        end
        PH_HCRC_LO: begin
          held = b;
          ph = PH_HCRC_HI;
        end
        PH_HCRC_HI: begin
          hcrc = {b, held};
          fin = 1'b1;
          sec = SEC_HCRC;
        end
        PH_PAYLOAD: k = K_PAYLOAD;
        default: begin
          k = K_BADFLAGS;
          ph = PH_ERROR;
        end
      endcase
      if (fin) begin
        if (sec < SEC_EXTRA && flag_bits[FLB_EXTRA]) ph = PH_XLEN_LO;
        else if (sec < SEC_NAME && flag_bits[FLB_NAME]) ph = PH_NAME;
        else if (sec < SEC_COMMENT && flag_bits[FLB_COMMENT]) ph = PH_COMMENT;
        else if (sec < SEC_HCRC && flag_bits[FLB_HCRC]) ph = PH_HCRC_LO;
        else begin
          ph = PH_PAYLOAD;
          k = K_LAST;
        end
      end
      r.kind = k;
      r.data = b;
      r.flags = flag_bits;
      r.crc = hcrc;
      results_due.push_back(r);
      kind_tally[int'(k)]++;
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= 40) $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Compare one result taken from the block against the oldest one due
    task check_result(parse_result_t got);
      parse_result_t want;
      if (results_due.size() == 0) begin
        report($sformatf("unexpected result kind %0d byte %02h", got.kind, got.data));
      end else begin
        want = results_due.pop_front();
        if (got.kind !== want.kind)
          report($sformatf("kind %0d, want %0d (byte %02h)", got.kind, want.kind, want.data));
        if (got.data !== want.data)
          report($sformatf("byte_out %02h, want %02h", got.data, want.data));
        if (got.flags !== want.flags)
          report($sformatf("header_flags %02h, want %02h (byte %02h)",
                           got.flags, want.flags, want.data));
        if (got.crc !== want.crc)
          report($sformatf("stored_header_crc %04h, want %04h (byte %02h)",
                           got.crc, want.crc, want.data));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;

  gzmh_in_if  in_bus();
  gzmh_out_if out_bus();

  gzip_member_header_parser uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_bus),
    .out_if (out_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  gzip_header_tracker board;

  int bytes_sent = 0;
  int members = 0;
  int burst_left = 0;
  int cycle_count = 0;
  int long_hold_ask = 0;
  // When set, the sender offers back-to-back with no gaps
  logic steady = 1'b0;

  // Receiver: ready follows a rotating 16-bit stall pattern, re-picked whenever its age count runs out.
  // A long hold requested by the stimulus overrides the pattern for its full count.
  initial begin
    logic [15:0] stall_pattern;
    int          pattern_age;
    int          hold_left;
    out_bus.ready = 1'b0;
    stall_pattern = 16'hFFFF;
    pattern_age = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (long_hold_ask > 0) begin
        hold_left = long_hold_ask;
        long_hold_ask = 0;
      end
      if (pattern_age == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pattern = 16'hFFFF;
          1: stall_pattern = 16'($urandom);
          2: stall_pattern = 16'($urandom) & 16'($urandom) & 16'($urandom);
          default: stall_pattern = 16'($urandom) | 16'($urandom);
        endcase
        // never lock the receiver shut
        if (stall_pattern == 16'h0000) stall_pattern = 16'h0001;
        pattern_age = 64;
      end
      pattern_age--;
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= stall_pattern[0];
      end
      stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
    end
  end

  // Monitor: sample the result channel at the rising edge, before the block updates it
  always @(posedge clk) begin
    parse_result_t got;
    if (rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      got.kind = kind_t'(out_bus.kind);
      got.data = out_bus.byte_out;
      got.flags = out_bus.header_flags;
      got.crc = out_bus.stored_header_crc;
      board.check_result(got);
    end
  end

  // Watchdog: end the run if the stream hangs
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
             board.results_due.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // Offer one byte and hold it until the block takes it. Bursts of random length are
  // separated by random gaps, during which valid drops and the payload carries junk.
  task automatic send_byte(input logic [7:0] b, input logic mark);
    int gap;
    if (burst_left <= 0) begin
      gap = steady ? 0 : $urandom_range(0, 12);
      burst_left = $urandom_range(1, 24);
      repeat (gap) begin
        @(negedge clk);
        in_bus.valid <= 1'b0;
        in_bus.data_byte <= 8'($urandom);
        in_bus.start_of_member <= 1'($urandom);
      end
    end
    @(negedge clk);
    in_bus.valid <= 1'b1;
    in_bus.data_byte <= b;
    in_bus.start_of_member <= mark;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    // transfer happened at this edge
    board.note_byte(b, mark);
    burst_left--;
    bytes_sent++;
  endtask

  // Build a member: magic, method and flags as given, six fixed bytes, then the optional
  // extra field, name, comment and header CRC that the low flag bits call for, then
  // payload. A non-negative cut keeps only the first cut bytes, so the next start mark
  // can land mid-header.
  task automatic send_member(input logic [7:0] m1, input logic [7:0] m2,
                             input logic [7:0] meth, input logic [7:0] flg,
                             input int xlen, input int nlen, input int clen,
                             input logic [15:0] crc, input int tail, input int cut,
                             input logic mark);
    logic [7:0] bytes_q[$];
    bytes_q = {m1, m2, meth, flg};
    repeat (6) bytes_q.push_back(8'($urandom));
    if (flg[FLB_EXTRA]) begin
      bytes_q.push_back(xlen[7:0]);
      bytes_q.push_back(xlen[15:8]);
      repeat (xlen) bytes_q.push_back(8'($urandom));
    end
    if (flg[FLB_NAME]) begin
      repeat (nlen) bytes_q.push_back(8'($urandom_range(1, 255)));
      bytes_q.push_back(8'h00);
    end
    if (flg[FLB_COMMENT]) begin
      repeat (clen) bytes_q.push_back(8'($urandom_range(1, 255)));
      bytes_q.push_back(8'h00);
    end
    if (flg[FLB_HCRC]) begin
      bytes_q.push_back(crc[7:0]);
      bytes_q.push_back(crc[15:8]);
    end
    repeat (tail) bytes_q.push_back(8'($urandom));
    if (cut >= 0) begin
      while (bytes_q.size() > cut) void'(bytes_q.pop_back());
    end
    foreach (bytes_q[i]) send_byte(bytes_q[i], (i == 0) && mark);
    members++;
  endtask

  // Drop valid and hold the sender until every result due has been taken
  task automatic wait_drained();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (board.results_due.size() != 0) @(posedge clk);
  endtask

  initial begin
    int         sel;
    int         xlen;
    logic [4:0] flg5;
    logic       hold_done;
    logic       drain_done;

    board = new();
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.data_byte = 8'h00;
    in_bus.start_of_member = 1'b0;
    hold_done = 1'b0;
    drain_done = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: first member with no start mark after reset, no optional sections, so the
    // sixth fixed byte closes the header; then two payload bytes.
    send_member(MAGIC_FIRST, MAGIC_SECOND, METHOD_DEFLATE, 8'h00, 0, 0, 0, 16'h0000,
                2, -1, 1'b0);
    // bad first magic byte, judged on the second; one byte after the error
    send_member(8'h00, MAGIC_SECOND, METHOD_DEFLATE, 8'h00, 0, 0, 0, 16'h0000, 0, 3, 1'b1);
    // bad second magic byte
    send_member(MAGIC_FIRST, 8'hFF, METHOD_DEFLATE, 8'h00, 0, 0, 0, 16'h0000, 0, 2, 1'b1);
    // bad method, then one byte stuck in error
    send_member(MAGIC_FIRST, MAGIC_SECOND, 8'h07, 8'h00, 0, 0, 0, 16'h0000, 0, 4, 1'b1);
    // every reserved flag bit set
    send_member(MAGIC_FIRST, MAGIC_SECOND, METHOD_DEFLATE, 8'hFF, 0, 0, 0, 16'h0000,
                0, 5, 1'b1);
    // restart mid-header, right after the method byte
    send_member(MAGIC_FIRST, MAGIC_SECOND, METHOD_DEFLATE, 8'h1F, 0, 0, 0, 16'h0000,
                0, 3, 1'b1);
    // all flags: zero-length extra, one-byte name, empty comment, CRC of all ones
    send_member(MAGIC_FIRST, MAGIC_SECOND, METHOD_DEFLATE, 8'h1F, 0, 1, 0, 16'hFFFF,
                1, -1, 1'b1);
    // bytes with no start mark while in payload keep flowing through
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);

    // Random: mostly well-formed members with random content, the rest broken or noise
    while (bytes_sent < RANDOM_BYTES + 60) begin
      steady = ($urandom_range(0, 9) == 0);
      if (!drain_done && bytes_sent > 500) begin
        // Pause the sender until the block has handed back everything
        wait_drained();
        drain_done = 1'b1;
      end
      if (!hold_done && bytes_sent > 900) begin
        // Hold the receiver off while the sender keeps offering
        long_hold_ask = LONG_HOLD;
        hold_done = 1'b1;
      end
      sel = $urandom_range(0, 99);
      flg5 = 5'($urandom);
      xlen = ($urandom_range(0, 24) == 0) ? $urandom_range(256, 300) : $urandom_range(0, 10);
      if (sel < 78) begin
        send_member(MAGIC_FIRST, MAGIC_SECOND, METHOD_DEFLATE, {3'b000, flg5}, xlen,
                    $urandom_range(0, 8), $urandom_range(0, 8), 16'($urandom),
                    $urandom_range(0, 12), (sel < 70) ? -1 : $urandom_range(1, 14), 1'b1);
      end else if (sel < 84) begin
        send_member($urandom_range(0, 1) ? MAGIC_FIRST : 8'($urandom),
                    $urandom_range(0, 1) ? MAGIC_SECOND : 8'($urandom),
                    METHOD_DEFLATE, {3'b000, flg5}, xlen, 2, 2, 16'($urandom), 2,
                    $urandom_range(2, 10), 1'b1);
      end else if (sel < 89) begin
        send_member(MAGIC_FIRST, MAGIC_SECOND, 8'($urandom), {3'b000, flg5}, xlen, 2, 2,
                    16'($urandom), 2, $urandom_range(3, 10), 1'b1);
      end else if (sel < 94) begin
        send_member(MAGIC_FIRST, MAGIC_SECOND, METHOD_DEFLATE,
                    {3'($urandom_range(1, 7)), flg5}, xlen, 2, 2, 16'($urandom), 2,
                    $urandom_range(4, 12), 1'b1);
      end else begin
        // noise, with the odd stray start mark
        repeat ($urandom_range(1, 8)) send_byte(8'($urandom), ($urandom_range(0, 7) == 0));
      end
    end

    @(negedge clk);
    in_bus.valid <= 1'b0;
    steady = 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d bytes in %0d members plus noise, in %0d cycles.",
             bytes_sent, members, cycle_count);
    $display("Results: header %0d, last %0d, payload %0d, bad magic %0d, bad method %0d, %s %0d.",
             board.kind_tally[K_HEADER], board.kind_tally[K_LAST],
             board.kind_tally[K_PAYLOAD], board.kind_tally[K_BADMAGIC],
             board.kind_tally[K_BADMETHOD], "bad flags or after error",
             board.kind_tally[K_BADFLAGS]);
    if (board.mismatches == 0 && board.results_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule : tb_gzip_member_header_parser

`default_nettype wire

// ===== files.f =====
rtl/gzmh_pkg.sv
rtl/gzmh_if.sv
rtl/gzip_member_header_parser.sv
test/tb_gzip_member_header_parser.sv
